>>> rtl/efd_pkg.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder package
// Shared widths, codes, the queue entry type and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package efd_pkg;

    localparam int LENGTH_BITS_DEFAULT = 16;
    localparam int BYTE_W              = 8;
    localparam int LEN_W               = 16;
    localparam int CFG_INDEX_W         = 2;
    localparam int CFG_DATA_W          = 16;
    localparam int QUEUE_DEPTH         = 4;
    localparam int QUEUE_PTR_W         = 2;

    localparam logic [BYTE_W-1:0] ESC_BYTE    = 8'h7D;
    localparam logic [BYTE_W-1:0] ESC_FLIP    = 8'h20;
    localparam logic [BYTE_W-1:0] DELIM_RESET = 8'h7E;
    localparam logic [15:0]       MAX_RESET   = 16'd4096;
    localparam logic [15:0]       CRC_POLY    = 16'h8408;
    localparam logic [15:0]       CRC_INIT    = 16'hFFFF;

    typedef enum logic [2:0] {
        STATUS_OK         = 3'd0,
        STATUS_TOO_SHORT  = 3'd1,
        STATUS_OVERFLOW   = 3'd2,
        STATUS_ESC_AT_END = 3'd3,
        STATUS_CRC_BAD    = 3'd4
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DELIMITER = 2'd0,
        CFG_MAX_BYTES = 2'd1
    } cfg_index_t;

    typedef struct packed {
        logic              is_end;
        logic [BYTE_W-1:0] data;
        status_t           pre_status;
        logic [LEN_W-1:0]  payload_len;
    } op_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [BYTE_W-1:0] b);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

>>> rtl/efd_front.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder front end
// Takes raw bytes, removes escapes, counts and checks the frame, and queues
// data bytes and end-of-frame events for the back end.
// ----------------------------------------------------------------------------
module efd_front #(
    parameter int LENGTH_BITS = efd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [efd_pkg::BYTE_W-1:0]         rx_byte,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [efd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [efd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               queue_full,
    output logic                               op_push,
    output efd_pkg::op_t                       op
);

    localparam int CMP_W = (LENGTH_BITS > efd_pkg::LEN_W) ? LENGTH_BITS : efd_pkg::LEN_W;
    localparam logic [LENGTH_BITS-1:0] CEILING = {LENGTH_BITS{1'b1}};

    logic [efd_pkg::BYTE_W-1:0] delim_reg;
    logic [15:0]                max_reg;
    logic                       esc_reg;
    logic                       esc_next;
    logic [1:0]                 raw_reg;
    logic [1:0]                 raw_next;
    logic [LENGTH_BITS-1:0]     cnt_reg;
    logic [LENGTH_BITS-1:0]     cnt_next;
    logic                       ovf_reg;
    logic                       ovf_next;

    logic                       accept;
    logic                       is_delim;
    logic                       have;
    logic                       take;
    logic [efd_pkg::BYTE_W-1:0] data;
    logic [LENGTH_BITS-1:0]     cnt_inc;
    logic                       ovf_hit;
    logic [LENGTH_BITS-1:0]     held;
    logic [CMP_W-1:0]           len_wide;
    efd_pkg::status_t           pre_status;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;

    assign is_delim = (rx_byte == delim_reg);
    assign have     = !is_delim && (esc_reg || (rx_byte != efd_pkg::ESC_BYTE));
    assign take     = have && !ovf_reg;
    assign data     = esc_reg ? (rx_byte ^ efd_pkg::ESC_FLIP) : rx_byte;
    assign cnt_inc  = (take && (cnt_reg != CEILING)) ? cnt_reg + 1'b1 : cnt_reg;
    assign ovf_hit  = ovf_reg || (CMP_W'(cnt_inc) >= CMP_W'(max_reg)) || (cnt_inc == CEILING);

    // The hold window holds the last two counted bytes, so its fill follows the count.
    assign held     = (cnt_reg >= LENGTH_BITS'(2)) ? LENGTH_BITS'(2) : cnt_reg;
    assign len_wide = CMP_W'(cnt_reg - held);

    always_comb
    begin
        if (raw_reg < 2'd3)
        begin
            pre_status = efd_pkg::STATUS_TOO_SHORT;
        end
        else if (ovf_reg)
        begin
            pre_status = efd_pkg::STATUS_OVERFLOW;
        end
        else if (esc_reg)
        begin
            pre_status = efd_pkg::STATUS_ESC_AT_END;
        end
        else
        begin
            pre_status = efd_pkg::STATUS_OK;
        end
    end

    assign op_push        = accept && (is_delim || take);
    assign op.is_end      = is_delim;
    assign op.data        = data;
    assign op.pre_status  = pre_status;
    assign op.payload_len = len_wide[efd_pkg::LEN_W-1:0];

    always_comb
    begin
        esc_next = esc_reg;
        raw_next = raw_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (is_delim)
            begin
                esc_next = 1'b0;
                raw_next = 2'd0;
                cnt_next = '0;
                ovf_next = 1'b0;
            end
            else
            begin
                esc_next = !esc_reg && (rx_byte == efd_pkg::ESC_BYTE);
                raw_next = (raw_reg < 2'd3) ? raw_reg + 2'd1 : raw_reg;
                cnt_next = cnt_inc;
                ovf_next = ovf_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delim_reg <= efd_pkg::DELIM_RESET;
            max_reg   <= efd_pkg::MAX_RESET;
            esc_reg   <= 1'b0;
            raw_reg   <= 2'd0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            esc_reg <= esc_next;
            raw_reg <= raw_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    efd_pkg::CFG_DELIMITER: delim_reg <= cfg_data[efd_pkg::BYTE_W-1:0];
                    efd_pkg::CFG_MAX_BYTES: max_reg   <= cfg_data[15:0];
                    default:                ;
                endcase
            end
        end
    end

endmodule

>>> rtl/efd_queue.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder operation queue
// A short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
module efd_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  efd_pkg::op_t push_op,
    input  logic         pop,
    output logic         full,
    output logic         not_empty,
    output efd_pkg::op_t head_op
);

    efd_pkg::op_t                   entry_reg [efd_pkg::QUEUE_DEPTH];
    logic [efd_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [efd_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [efd_pkg::QUEUE_PTR_W:0]   fill_reg;
    logic [efd_pkg::QUEUE_PTR_W:0]   fill_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (fill_reg == (efd_pkg::QUEUE_PTR_W + 1)'(efd_pkg::QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

>>> rtl/efd_back.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder back end
// Runs the two-byte hold window and the CRC-16, and drives the result
// register towards the consumer.
// ----------------------------------------------------------------------------
module efd_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          op_valid,
    input  efd_pkg::op_t                  op,
    output logic                          op_pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          kind,
    output logic [efd_pkg::BYTE_W-1:0]    data_byte,
    output logic [2:0]                    status,
    output logic [efd_pkg::LEN_W-1:0]     payload_len
);

    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [1:0]                 fill_reg;
    logic [1:0]                 fill_next;
    logic [15:0]                crc_reg;
    logic [15:0]                crc_next;
    logic [efd_pkg::BYTE_W-1:0] win0_reg;
    logic [efd_pkg::BYTE_W-1:0] win0_next;
    logic [efd_pkg::BYTE_W-1:0] win1_reg;
    logic [efd_pkg::BYTE_W-1:0] win1_next;
    logic                       kind_reg;
    logic                       kind_next;
    logic [efd_pkg::BYTE_W-1:0] data_reg;
    logic [efd_pkg::BYTE_W-1:0] data_next;
    efd_pkg::status_t           status_reg;
    efd_pkg::status_t           status_next;
    logic [efd_pkg::LEN_W-1:0]  len_reg;
    logic [efd_pkg::LEN_W-1:0]  len_next;
    logic                       advance;
    logic                       crc_match;

    assign advance   = !out_valid_reg || !out_stall;
    assign op_pop    = op_valid && advance;
    assign crc_match = ((~crc_reg) == {win1_reg, win0_reg});

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_reg;
    assign status      = status_reg;
    assign payload_len = len_reg;

    always_comb
    begin
        out_valid_next = advance ? 1'b0 : out_valid_reg;
        fill_next      = fill_reg;
        crc_next       = crc_reg;
        win0_next      = win0_reg;
        win1_next      = win1_reg;
        kind_next      = kind_reg;
        data_next      = data_reg;
        status_next    = status_reg;
        len_next       = len_reg;
        if (op_pop)
        begin
            if (op.is_end)
            begin
                out_valid_next = 1'b1;
                kind_next      = 1'b1;
                data_next      = '0;
                len_next       = op.payload_len;
                if (op.pre_status != efd_pkg::STATUS_OK)
                begin
                    status_next = op.pre_status;
                end
                else if ((fill_reg < 2'd2) || !crc_match)
                begin
                    status_next = efd_pkg::STATUS_CRC_BAD;
                end
                else
                begin
                    status_next = efd_pkg::STATUS_OK;
                end
                fill_next = 2'd0;
                crc_next  = efd_pkg::CRC_INIT;
            end
            else if (fill_reg == 2'd2)
            begin
                out_valid_next = 1'b1;
                kind_next      = 1'b0;
                data_next      = win0_reg;
                status_next    = efd_pkg::STATUS_OK;
                len_next       = '0;
                crc_next       = efd_pkg::crc16_byte(crc_reg, win0_reg);
                win0_next      = win1_reg;
                win1_next      = op.data;
            end
            else
            begin
                if (fill_reg == 2'd0)
                begin
                    win0_next = op.data;
                end
                else
                begin
                    win1_next = op.data;
                end
                fill_next = fill_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fill_reg      <= 2'd0;
            crc_reg       <= efd_pkg::CRC_INIT;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            crc_reg       <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win0_reg   <= win0_next;
        win1_reg   <= win1_next;
        kind_reg   <= kind_next;
        data_reg   <= data_next;
        status_reg <= status_next;
        len_reg    <= len_next;
    end

endmodule

>>> rtl/escaped_frame_decoder_crc16.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder with CRC-16 check
// Removes byte escapes from a delimited stream, emits payload bytes and one
// end-of-frame transfer with a status and the payload length.
// ----------------------------------------------------------------------------
// The block takes one received byte in every cycle unless in_stall is high
// and gives at most one result per byte; a taken byte passes through the
// four-entry queue between the escape and length front end and the window
// and CRC back end into the output register. The CRC-16 update of a byte
// is combinational in the back end. When the consumer stalls, the queue
// fills and the input stalls once it holds four pending operations; escape
// bytes and bytes dropped after an overflow never enter the queue.
module escaped_frame_decoder_crc16 #(
    parameter int LENGTH_BITS = efd_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [efd_pkg::BYTE_W-1:0]      rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            kind,
    output logic [efd_pkg::BYTE_W-1:0]      data_byte,
    output logic [2:0]                      status,
    output logic [efd_pkg::LEN_W-1:0]       payload_len,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [efd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [efd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    efd_pkg::op_t push_op;
    efd_pkg::op_t head_op;
    logic         op_push;
    logic         op_pop;
    logic         queue_full;
    logic         queue_not_empty;

    efd_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .op_push    (op_push),
        .op         (push_op)
    );

    efd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (op_push),
        .push_op   (push_op),
        .pop       (op_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_op   (head_op)
    );

    efd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (queue_not_empty),
        .op          (head_op),
        .op_pop      (op_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .status      (status),
        .payload_len (payload_len)
    );

endmodule

>>> tb/escaped_frame_decoder_crc16_tb.sv
// ----------------------------------------------------------------------------
// Escaped frame decoder testbench
// Sends escaped, delimited byte streams with real and broken CRC trailers
// under several delimiter and length-limit settings, predicts every payload
// and end-of-frame transfer in step with the accepted bytes, and checks each
// output transfer field by field.
// ----------------------------------------------------------------------------
module escaped_frame_decoder_crc16_tb;

    typedef struct packed {
        logic             kind;
        logic [7:0]       data;
        efd_pkg::status_t status;
        logic [15:0]      len;
    } frame_result_t;

    typedef enum logic [1:0] {
        ROW_RAW,
        ROW_DATA,
        ROW_CRC,
        ROW_DELIM
    } row_op_t;

    typedef struct {
        row_op_t       op;
        logic [7:0]    value;
        logic          typed;
        frame_result_t result;
    } script_row_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        kind;
    logic [7:0]  data_byte;
    logic [2:0]  status;
    logic [15:0] payload_len;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [15:0] cfg_data = 16'h0000;

    // Configuration and frame state as the decoder should hold them.
    logic [7:0]  cur_delim = efd_pkg::DELIM_RESET;
    logic [15:0] cur_limit = efd_pkg::MAX_RESET;
    logic        esc_flag = 1'b0;
    logic [1:0]  raw_seen = 2'd0;
    logic [15:0] ucount = 16'd0;
    logic        ovf_flag = 1'b0;
    logic [15:0] crc_run = efd_pkg::CRC_INIT;
    logic [7:0]  win [2];
    logic [1:0]  win_fill = 2'd0;

    frame_result_t decode_q [$];
    frame_result_t head_r;
    logic [7:0]    tx_bytes [$];
    logic [15:0]   tx_crc = efd_pkg::CRC_INIT;

    int           fails = 0;
    int           bytes_sent = 0;
    int           payload_seen = 0;
    int           end_seen [5];
    int           burst_left = 0;
    bit           quiet = 1'b0;
    int           stall_tick = 0;
    stall_style_t stall_mode = STALL_NONE;
    script_row_t  script [23];

    escaped_frame_decoder_crc16 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .status      (status),
        .payload_len (payload_len),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    always @(negedge clk)
    begin
        stall_tick = stall_tick + 1;
        if (stall_tick % 64 == 0)
        begin
            stall_mode = stall_style_t'($urandom_range(0, 2));
        end
        if (quiet)
        begin
            out_stall = 1'b0;
        end
        else
        begin
            case (stall_mode)
                STALL_NONE:     out_stall = 1'b0;
                STALL_RANDOM:   out_stall = ($urandom_range(0, 99) < 40);
                default:        out_stall = ((stall_tick % 9) < 4);
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decode_q.size() == 0)
            begin
                $error("Output transfer with nothing expected: kind %0d data %0h",
                       kind, data_byte);
                fails++;
            end
            else
            begin
                head_r = decode_q.pop_front();
                if (kind !== head_r.kind)
                begin
                    $error("kind: expected %0d, got %0d", head_r.kind, kind);
                    fails++;
                end
                if (data_byte !== head_r.data)
                begin
                    $error("data_byte: expected %0h, got %0h", head_r.data, data_byte);
                    fails++;
                end
                if (status !== head_r.status)
                begin
                    $error("status: expected %0d, got %0d", head_r.status, status);
                    fails++;
                end
                if (payload_len !== head_r.len)
                begin
                    $error("payload_len: expected %0d, got %0d", head_r.len, payload_len);
                    fails++;
                end
                if (head_r.kind)
                begin
                    end_seen[head_r.status]++;
                end
                else
                begin
                    payload_seen++;
                end
            end
        end
    end

    function automatic logic [15:0] crc_x25_update(input logic [15:0] crc,
                                                   input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        int          i;
        c = crc;
        for (i = 0; i < 8; i++)
        begin
            fb = c[0] ^ b[i];
            c = c >> 1;
            if (fb)
            begin
                c = c ^ efd_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    task automatic deframe_byte(input logic [7:0] b, output logic got,
                                output frame_result_t r);
        logic [7:0]       d;
        logic             have;
        efd_pkg::status_t st;
        got = 1'b0;
        r = '0;
        have = 1'b0;
        d = 8'h00;
        if (b == cur_delim)
        begin
            if (raw_seen < 2'd3)
                st = efd_pkg::STATUS_TOO_SHORT;
            else if (ovf_flag)
                st = efd_pkg::STATUS_OVERFLOW;
            else if (esc_flag)
                st = efd_pkg::STATUS_ESC_AT_END;
            else if (win_fill < 2'd2)
                st = efd_pkg::STATUS_CRC_BAD;
            else if (~crc_run == {win[1], win[0]})
                st = efd_pkg::STATUS_OK;
            else
                st = efd_pkg::STATUS_CRC_BAD;
            r = '{1'b1, 8'h00, st, ucount - {14'd0, win_fill}};
            got = 1'b1;
            esc_flag = 1'b0;
            raw_seen = 2'd0;
            ucount = 16'd0;
            ovf_flag = 1'b0;
            crc_run = efd_pkg::CRC_INIT;
            win_fill = 2'd0;
            return;
        end
        if (raw_seen < 2'd3)
        begin
            raw_seen++;
        end
        if (esc_flag)
        begin
            d = b ^ efd_pkg::ESC_FLIP;
            esc_flag = 1'b0;
            have = 1'b1;
        end
        else if (b == efd_pkg::ESC_BYTE)
        begin
            esc_flag = 1'b1;
        end
        else
        begin
            d = b;
            have = 1'b1;
        end
        if (have && !ovf_flag)
        begin
            if (win_fill == 2'd2)
            begin
                crc_run = crc_x25_update(crc_run, win[0]);
                r = '{1'b0, win[0], efd_pkg::STATUS_OK, 16'd0};
                got = 1'b1;
                win[0] = win[1];
                win[1] = d;
            end
            else
            begin
                win[win_fill[0]] = d;
                win_fill++;
            end
            if (ucount != 16'hFFFF)
            begin
                ucount++;
            end
        end
        if (!ovf_flag && (ucount >= cur_limit || ucount == 16'hFFFF))
        begin
            ovf_flag = 1'b1;
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input frame_result_t typed_r);
        logic          got;
        frame_result_t r;
        int            gap;
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            gap = (quiet || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid = 1'b1;
        rx_byte = b;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        bytes_sent++;
        deframe_byte(b, got, r);
        if (typed)
            decode_q.push_back(typed_r);
        else if (got)
            decode_q.push_back(r);
        @(negedge clk);
    endtask

    task automatic send_queue();
        while (tx_bytes.size() != 0)
        begin
            send_byte(tx_bytes.pop_front(), 1'b0, '0);
        end
    endtask

    task automatic encode_byte(input logic [7:0] d);
        logic want_esc;
        want_esc = (d == cur_delim) || (d == efd_pkg::ESC_BYTE) ||
                   ($urandom_range(0, 15) == 0 && (d ^ efd_pkg::ESC_FLIP) != cur_delim);
        if (want_esc && cur_delim != efd_pkg::ESC_BYTE)
        begin
            tx_bytes.push_back(efd_pkg::ESC_BYTE);
            tx_bytes.push_back(d ^ efd_pkg::ESC_FLIP);
        end
        else
        begin
            tx_bytes.push_back(d);
        end
    endtask

    task automatic append_data(input logic [7:0] d);
        tx_crc = crc_x25_update(tx_crc, d);
        encode_byte(d);
    endtask

    task automatic append_crc();
        encode_byte(~tx_crc[7:0]);
        encode_byte(~tx_crc[15:8]);
    endtask

    function automatic logic [7:0] data_pick();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return cur_delim;
        else if (r == 1)
            return efd_pkg::ESC_BYTE;
        return 8'($urandom);
    endfunction

    task automatic drain();
        in_valid = 1'b0;
        while (decode_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input efd_pkg::cfg_index_t idx, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (idx == efd_pkg::CFG_DELIMITER)
            cur_delim = val[7:0];
        else if (idx == efd_pkg::CFG_MAX_BYTES)
            cur_limit = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic gen_frame();
        int form;
        int n;
        int r;
        int idx;
        if ($urandom_range(0, 24) == 0)
        begin
            drain();
        end
        form = $urandom_range(0, 99);
        tx_crc = efd_pkg::CRC_INIT;
        if (form >= 94)
        begin
            repeat ($urandom_range(0, 8)) tx_bytes.push_back(8'($urandom));
        end
        else
        begin
            r = $urandom_range(0, 9);
            n = (r < 7) ? $urandom_range(0, 8) :
                (r < 9) ? $urandom_range(9, 40) : $urandom_range(41, 90);
            repeat (n) append_data(data_pick());
            if (form < 88)
            begin
                append_crc();
            end
            else
            begin
                tx_bytes.push_back(efd_pkg::ESC_BYTE);
            end
            if (form >= 70 && form < 80)
            begin
                idx = $urandom_range(0, tx_bytes.size() - 1);
                tx_bytes[idx] = tx_bytes[idx] ^ 8'($urandom_range(1, 255));
            end
            else if (form >= 80 && form < 88)
            begin
                repeat ($urandom_range(1, tx_bytes.size())) void'(tx_bytes.pop_back());
            end
        end
        send_queue();
        send_byte(cur_delim, 1'b0, '0);
    endtask

    task automatic send_long_frame();
        quiet = 1'b1;
        tx_crc = efd_pkg::CRC_INIT;
        repeat (int'(cur_limit) + 4)
        begin
            append_data(data_pick());
            send_queue();
        end
        send_byte(cur_delim, 1'b0, '0);
        quiet = 1'b0;
    endtask

    task automatic run_phase(input logic [7:0] d, input logic [15:0] lim,
                             input int goal, input bit long_frame);
        int start;
        drain();
        repeat (8) @(negedge clk);
        write_reg(efd_pkg::CFG_DELIMITER, {8'h00, d});
        write_reg(efd_pkg::CFG_MAX_BYTES, lim);
        if (long_frame)
        begin
            send_long_frame();
        end
        start = bytes_sent;
        while (bytes_sent - start < goal)
        begin
            gen_frame();
        end
    endtask

    initial
    begin
        int i;
        int waited;
        script = '{
            '{ROW_DELIM, 8'h00, 1'b1, '{1'b1, 8'h00, efd_pkg::STATUS_TOO_SHORT, 16'd0}},
            '{ROW_RAW,   8'h00, 1'b0, '0},
            '{ROW_RAW,   8'hFF, 1'b0, '0},
            '{ROW_DELIM, 8'h00, 1'b1, '{1'b1, 8'h00, efd_pkg::STATUS_TOO_SHORT, 16'd0}},
            '{ROW_RAW,   8'h7D, 1'b0, '0},
            '{ROW_RAW,   8'h7D, 1'b0, '0},
            '{ROW_RAW,   8'h7D, 1'b0, '0},
            '{ROW_DELIM, 8'h00, 1'b1, '{1'b1, 8'h00, efd_pkg::STATUS_ESC_AT_END, 16'd0}},
            '{ROW_DATA,  8'h7E, 1'b0, '0},
            '{ROW_DATA,  8'h7D, 1'b0, '0},
            '{ROW_DATA,  8'h00, 1'b0, '0},
            '{ROW_DATA,  8'hFF, 1'b0, '0},
            '{ROW_CRC,   8'h00, 1'b0, '0},
            '{ROW_DELIM, 8'h00, 1'b1, '{1'b1, 8'h00, efd_pkg::STATUS_OK, 16'd4}},
            '{ROW_DATA,  8'h12, 1'b0, '0},
            '{ROW_DATA,  8'h34, 1'b0, '0},
            '{ROW_RAW,   8'h00, 1'b0, '0},
            '{ROW_RAW,   8'h00, 1'b0, '0},
            '{ROW_DELIM, 8'h00, 1'b0, '0},
            '{ROW_DATA,  8'hA5, 1'b0, '0},
            '{ROW_DATA,  8'h5A, 1'b0, '0},
            '{ROW_RAW,   8'h7D, 1'b0, '0},
            '{ROW_DELIM, 8'h00, 1'b1, '{1'b1, 8'h00, efd_pkg::STATUS_ESC_AT_END, 16'd0}}
        };
        for (i = 0; i < 5; i++)
        begin
            end_seen[i] = 0;
        end
        win[0] = 8'h00;
        win[1] = 8'h00;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        for (i = 0; i < 23; i++)
        begin
            case (script[i].op)
                ROW_DATA:
                begin
                    append_data(script[i].value);
                    send_queue();
                end
                ROW_CRC:
                begin
                    append_crc();
                    send_queue();
                end
                ROW_DELIM:
                begin
                    send_byte(cur_delim, script[i].typed, script[i].result);
                    tx_crc = efd_pkg::CRC_INIT;
                end
                default:
                begin
                    send_byte(script[i].value, script[i].typed, script[i].result);
                end
            endcase
        end

        run_phase(8'h7E, 16'd4096, 250, 1'b0);
        run_phase(8'h7D, 16'd4, 150, 1'b0);
        run_phase(8'h00, 16'd120, 100, 1'b1);
        run_phase(8'hFF, 16'($urandom_range(5, 20)), 200, 1'b0);
        run_phase(8'($urandom), 16'($urandom_range(4, 64)), 200, 1'b0);

        in_valid = 1'b0;
        waited = 0;
        while (decode_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        if (decode_q.size() != 0)
        begin
            $error("%0d expected transfers never arrived", decode_q.size());
            fails++;
        end
        repeat (20) @(posedge clk);

        $display("Sent %0d bytes; checked %0d payload transfers and frame ends:",
                 bytes_sent, payload_seen);
        $display("  ok %0d, too short %0d, overflow %0d, escape at end %0d, CRC bad %0d",
                 end_seen[0], end_seen[1], end_seen[2], end_seen[3], end_seen[4]);
        if (fails == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
